### rtl/core/i2cts_pkg.sv
package i2cts_pkg;

	localparam int unsigned TX_DEPTH_DEF = 16;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10;

	typedef enum logic [2:0] {
		OP_START       = 3'd0,
		OP_MASTER_EVT  = 3'd1,
		OP_SLAVE_BYTE  = 3'd2,
		OP_TICK        = 3'd3,
		OP_CLOSE       = 3'd4,
		OP_CLEAR_ERR   = 3'd5,
		OP_LOAD_TX     = 3'd6,
		OP_BUS_ERR     = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CMD     = 3'd1,
		PH_DATA    = 3'd2,
		PH_RX      = 3'd3,
		PH_UNREACH = 3'd4,
		PH_ERROR   = 3'd5
	} phase_t;

	localparam logic [1:0] BUS_NONE    = 2'd0;
	localparam logic [1:0] BUS_RESTART = 2'd1;
	localparam logic [1:0] BUS_READ    = 2'd2;
	localparam logic [1:0] BUS_STOP    = 2'd3;

	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_ACK  = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;

	localparam logic [1:0] BYTE_NONE = 2'd0;
	localparam logic [1:0] BYTE_TX   = 2'd1;
	localparam logic [1:0] BYTE_RX   = 2'd2;

	typedef struct packed {
		opcode_t     opcode;
		logic [6:0]  target_address;
		logic [7:0]  command_byte;
		logic [4:0]  tx_count;
		logic [7:0]  rx_count;
		logic [7:0]  requested_number;
		logic        bus_idle;
		logic        nack_received;
		logic [7:0]  data_byte;
		logic [3:0]  tx_index;
	} item_t;

	typedef struct packed {
		logic [7:0] accepted_number;
		logic [1:0] bus_command;
		logic       address_valid;
		logic [7:0] address_byte;
		logic [1:0] byte_action;
		logic [7:0] byte_value;
		logic [7:0] byte_index;
		logic [1:0] ack_action;
		logic       clear_master_flag;
		phase_t     status;
		logic [7:0] current_number;
	} result_t;

endpackage

### rtl/core/i2c_transaction_sequencer.sv
// i2c write-then-read transaction sequencer, driven by events from a byte-level bus engine
//
// request channel (in_valid/in_ready): one request per opcode - start, master-bus event,
// slave-bus byte, ms tick, close, clear error, load tx byte, bus error. fields are sampled
// into an input register when in_valid and in_ready are both high.
// result channel (out_valid/out_ready): exactly one result per request, in order, telling
// the bus engine what to send or issue next and reporting status and transaction number.
// cfg_wr_en/cfg_wr_data write timeout_ms; the user must write only while no request is in flight (unenforced).
//
// a request is taken into the input register when accepted and its result into the result
// register when it advances, which a full result register with out_ready low can delay.
// throughput: one request per cycle while out_ready is high; each state update is
// combinational, and the transmit buffer read is prefetched at the next request's position.
// when out_ready is low the result register holds and one more request may wait in the
// input register; in_ready drops only when both are full.
// reset clears state to idle, numbers to zero and timeout_ms to 10. the transmit buffer
// is not cleared; its entries are defined only once loaded.
module i2c_transaction_sequencer
	import i2cts_pkg::*;
#(
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [6:0]  target_address,
	input  logic [7:0]  command_byte,
	input  logic [4:0]  tx_count,
	input  logic [7:0]  rx_count,
	input  logic [7:0]  requested_number,
	input  logic        bus_idle,
	input  logic        nack_received,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  tx_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  accepted_number,
	output logic [1:0]  bus_command,
	output logic        address_valid,
	output logic [7:0]  address_byte,
	output logic [1:0]  byte_action,
	output logic [7:0]  byte_value,
	output logic [7:0]  byte_index,
	output logic [1:0]  ack_action,
	output logic        clear_master_flag,
	output logic [2:0]  status,
	output logic [7:0]  current_number
);

	localparam int unsigned AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(TX_DEPTH);

	// pipeline
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	// state
	logic [15:0] timeout_q;
	phase_t      phase_q, phase_d;
	logic [7:0]  position_q, position_d;
	logic [4:0]  send_count_q, send_count_d;
	logic [7:0]  receive_count_q, receive_count_d;
	logic [6:0]  address_q, address_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  active_q, active_d;
	logic [7:0]  last_q, last_d;
	logic [15:0] quiet_q, quiet_d;

	// transmit buffer
	logic [7:0]    send_buffer [TX_DEPTH];
	logic [7:0]    rd_q;
	logic [7:0]    pos_next;
	logic          mem_we;
	logic [8:0]    tidx_ext;
	logic [AW-1:0] waddr;

	// decode helpers
	phase_t      start_phase;
	logic        start_ok;
	logic [7:0]  alloc_number;
	logic        tx_more;
	logic        rx_more;
	logic [15:0] quiet_inc;
	logic        timeout_hit;
	logic [8:0]  txc_ext;
	result_t     res_d;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode           <= opcode_t'(opcode);
			item_s1.target_address   <= target_address;
			item_s1.command_byte     <= command_byte;
			item_s1.tx_count         <= tx_count;
			item_s1.rx_count         <= rx_count;
			item_s1.requested_number <= requested_number;
			item_s1.bus_idle         <= bus_idle;
			item_s1.nack_received    <= nack_received;
			item_s1.data_byte        <= data_byte;
			item_s1.tx_index         <= tx_index;
		end
	end

	always_comb begin
		start_phase  = (item_s1.bus_idle || phase_q == PH_UNREACH) ? PH_IDLE : phase_q;
		start_ok     = (start_phase == PH_IDLE);
		alloc_number = (last_q == 8'hFF) ? 8'd1 : last_q + 8'd1;
		tx_more      = ({1'b0, position_q} < {4'b0, send_count_q}) &&
		               ({1'b0, position_q} < DEPTH9);
		rx_more      = ({1'b0, position_q} + 9'd1) < {1'b0, receive_count_q};
		quiet_inc    = quiet_q + 16'd1;
		timeout_hit  = (quiet_inc >= timeout_q);
		txc_ext      = {4'b0, item_s1.tx_count};
		tidx_ext     = {5'b0, item_s1.tx_index};
	end

	// next state
	always_comb begin
		phase_d         = phase_q;
		position_d      = position_q;
		send_count_d    = send_count_q;
		receive_count_d = receive_count_q;
		address_d       = address_q;
		command_d       = command_q;
		active_d        = active_q;
		last_d          = last_q;
		quiet_d         = quiet_q;
		unique case (item_s1.opcode)
			OP_START: begin
				phase_d = start_phase;
				if (start_ok) begin
					command_d       = item_s1.command_byte;
					send_count_d    = (txc_ext > DEPTH9) ? DEPTH9[4:0] : item_s1.tx_count;
					receive_count_d = item_s1.rx_count;
					address_d       = item_s1.target_address;
					if (item_s1.requested_number != 8'd0) begin
						active_d = item_s1.requested_number;
					end else begin
						active_d = alloc_number;
						last_d   = alloc_number;
					end
					phase_d = PH_CMD;
				end
			end
			OP_MASTER_EVT: begin
				quiet_d = '0;
				if (item_s1.nack_received) begin
					phase_d = (phase_q == PH_CMD) ? PH_UNREACH : PH_ERROR;
				end else if (phase_q == PH_CMD) begin
					position_d = '0;
					phase_d    = PH_DATA;
				end else if (phase_q == PH_DATA) begin
					if (tx_more) begin
						position_d = position_q + 8'd1;
					end else if (receive_count_q != 8'd0) begin
						phase_d    = PH_RX;
						position_d = '0;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			OP_SLAVE_BYTE: begin
				quiet_d = '0;
				if (phase_q == PH_RX) begin
					if (rx_more) begin
						position_d = position_q + 8'd1;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			OP_TICK: begin
				quiet_d = quiet_inc;
				if (timeout_hit) begin
					quiet_d = '0;
					if (phase_q != PH_IDLE) begin
						phase_d = PH_ERROR;
					end
				end
			end
			OP_CLOSE: begin
				if (active_q == item_s1.requested_number) begin
					active_d = '0;
					phase_d  = PH_IDLE;
				end
			end
			OP_CLEAR_ERR: begin
				if (phase_q == PH_ERROR) begin
					phase_d = PH_IDLE;
				end
			end
			OP_LOAD_TX: begin
			end
			OP_BUS_ERR: begin
				phase_d = PH_IDLE;
				quiet_d = '0;
			end
		endcase
	end

	// result fields
	always_comb begin
		res_d                = '0;
		res_d.status         = phase_d;
		res_d.current_number = active_d;
		unique case (item_s1.opcode)
			OP_START: begin
				if (start_ok) begin
					res_d.accepted_number = active_d;
					res_d.ack_action      = ACK_NACK;
					res_d.address_valid   = 1'b1;
					res_d.address_byte    = {item_s1.target_address, 1'b0};
				end
			end
			OP_MASTER_EVT: begin
				if (item_s1.nack_received) begin
					res_d.clear_master_flag = 1'b1;
					res_d.bus_command       = BUS_STOP;
				end else if (phase_q == PH_CMD) begin
					res_d.byte_action = BYTE_TX;
					res_d.byte_value  = command_q;
				end else if (phase_q == PH_DATA) begin
					if (tx_more) begin
						res_d.byte_action = BYTE_TX;
						res_d.byte_value  = rd_q;
					end else if (receive_count_q != 8'd0) begin
						res_d.bus_command   = BUS_RESTART;
						res_d.address_valid = 1'b1;
						res_d.address_byte  = {address_q, 1'b1};
					end else begin
						res_d.bus_command = BUS_STOP;
					end
				end else if (phase_q == PH_IDLE) begin
					res_d.clear_master_flag = 1'b1;
				end
			end
			OP_SLAVE_BYTE: begin
				if (phase_q == PH_RX) begin
					res_d.byte_action = BYTE_RX;
					res_d.byte_value  = item_s1.data_byte;
					res_d.byte_index  = position_q;
					res_d.ack_action  = rx_more ? ACK_ACK : ACK_NACK;
					res_d.bus_command = rx_more ? BUS_READ : BUS_STOP;
				end else if (phase_q == PH_IDLE) begin
					res_d.ack_action  = ACK_NACK;
					res_d.bus_command = BUS_STOP;
				end
			end
			OP_TICK, OP_CLOSE, OP_CLEAR_ERR, OP_LOAD_TX, OP_BUS_ERR: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q       <= TIMEOUT_RESET;
			phase_q         <= PH_IDLE;
			position_q      <= '0;
			send_count_q    <= '0;
			receive_count_q <= '0;
			address_q       <= '0;
			command_q       <= '0;
			active_q        <= '0;
			last_q          <= '0;
			quiet_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (advance) begin
				phase_q         <= phase_d;
				position_q      <= position_d;
				send_count_q    <= send_count_d;
				receive_count_q <= receive_count_d;
				address_q       <= address_d;
				command_q       <= command_d;
				active_q        <= active_d;
				last_q          <= last_d;
				quiet_q         <= quiet_d;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// buffer read is prefetched at the position the next request will see
	assign pos_next = advance ? position_d : position_q;
	assign mem_we   = advance && (item_s1.opcode == OP_LOAD_TX) && (tidx_ext < DEPTH9);
	assign waddr    = tidx_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			send_buffer[waddr] <= item_s1.data_byte;
		end
		if (mem_we && waddr == pos_next[AW-1:0]) begin
			rd_q <= item_s1.data_byte;
		end else begin
			rd_q <= send_buffer[pos_next[AW-1:0]];
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted_number   = res_q.accepted_number;
	assign bus_command       = res_q.bus_command;
	assign address_valid     = res_q.address_valid;
	assign address_byte      = res_q.address_byte;
	assign byte_action       = res_q.byte_action;
	assign byte_value        = res_q.byte_value;
	assign byte_index        = res_q.byte_index;
	assign ack_action        = res_q.ack_action;
	assign clear_master_flag = res_q.clear_master_flag;
	assign status            = res_q.status;
	assign current_number    = res_q.current_number;

`ifndef SYNTHESIS
	a_grant_sends_address: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted_number != 8'd0) |->
		(address_valid && ack_action == ACK_NACK && current_number == accepted_number))
		else $error("granted start without address byte");

	a_read_bit_with_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && address_valid) |-> (address_byte[0] == (bus_command == BUS_RESTART)))
		else $error("read bit does not match repeated start");

	a_rx_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_action == BYTE_RX) |->
		(status == PH_RX || status == PH_IDLE))
		else $error("received byte outside receive phase");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("request stalled with room in pipeline");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after advance");
`endif

endmodule

### tb/i2c_transaction_sequencer_test.sv
module i2c_transaction_sequencer_test;
	import i2cts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = TX_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = '0;
	logic [6:0]  target_address = '0;
	logic [7:0]  command_byte = '0;
	logic [4:0]  tx_count = '0;
	logic [7:0]  rx_count = '0;
	logic [7:0]  requested_number = '0;
	logic        bus_idle = 1'b0;
	logic        nack_received = 1'b0;
	logic [7:0]  data_byte = '0;
	logic [3:0]  tx_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  accepted_number;
	logic [1:0]  bus_command;
	logic        address_valid;
	logic [7:0]  address_byte;
	logic [1:0]  byte_action;
	logic [7:0]  byte_value;
	logic [7:0]  byte_index;
	logic [1:0]  ack_action;
	logic        clear_master_flag;
	logic [2:0]  status;
	logic [7:0]  current_number;

	item_t   request_backlog[$];
	result_t owed_results[$];
	int      requests_queued = 0;
	int      requests_taken = 0;
	int      results_seen = 0;
	int      mismatch_count = 0;
	logic    req_taken = 1'b0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	logic    hold_go = 1'b0;
	int      hold_left = 0;
	int unsigned cycle_count = 0;

	// sequencer state as the predictor sees it
	phase_t      sq_phase = PH_IDLE;
	logic [7:0]  sq_pos = '0;
	logic [4:0]  sq_send = '0;
	logic [7:0]  sq_rcv = '0;
	logic [6:0]  sq_addr = '0;
	logic [7:0]  sq_cmd = '0;
	logic [7:0]  sq_active = '0;
	logic [7:0]  sq_last = '0;
	logic [15:0] sq_quiet = '0;
	logic [15:0] sq_timeout = TIMEOUT_RESET;
	logic [7:0]  tx_store[DEPTH];

	i2c_transaction_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.target_address(target_address),
		.command_byte(command_byte),
		.tx_count(tx_count),
		.rx_count(rx_count),
		.requested_number(requested_number),
		.bus_idle(bus_idle),
		.nack_received(nack_received),
		.data_byte(data_byte),
		.tx_index(tx_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted_number(accepted_number),
		.bus_command(bus_command),
		.address_valid(address_valid),
		.address_byte(address_byte),
		.byte_action(byte_action),
		.byte_value(byte_value),
		.byte_index(byte_index),
		.ack_action(ack_action),
		.clear_master_flag(clear_master_flag),
		.status(status),
		.current_number(current_number)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic result_t advance_sequencer(item_t rq);
		result_t r;
		r = '0;
		case (rq.opcode)
			OP_START: begin
				if (rq.bus_idle)
					sq_phase = PH_IDLE;
				if (sq_phase == PH_UNREACH)
					sq_phase = PH_IDLE;
				if (sq_phase == PH_IDLE) begin
					sq_cmd = rq.command_byte;
					sq_send = (rq.tx_count > DEPTH) ? 5'(DEPTH) : rq.tx_count;
					sq_rcv = rq.rx_count;
					sq_addr = rq.target_address;
					if (rq.requested_number != 8'd0) begin
						sq_active = rq.requested_number;
					end else begin
						// allocation never hands out zero
						sq_last = sq_last + 8'd1;
						if (sq_last == 8'd0)
							sq_last = 8'd1;
						sq_active = sq_last;
					end
					r.accepted_number = sq_active;
					r.ack_action = ACK_NACK;
					r.address_valid = 1'b1;
					r.address_byte = {rq.target_address, 1'b0};
					sq_phase = PH_CMD;
				end
			end
			OP_MASTER_EVT: begin
				sq_quiet = '0;
				if (rq.nack_received) begin
					sq_phase = (sq_phase == PH_CMD) ? PH_UNREACH : PH_ERROR;
					r.clear_master_flag = 1'b1;
					r.bus_command = BUS_STOP;
				end else begin
					case (sq_phase)
						PH_CMD: begin
							r.byte_action = BYTE_TX;
							r.byte_value = sq_cmd;
							sq_pos = '0;
							sq_phase = PH_DATA;
						end
						PH_DATA: begin
							if (sq_pos < sq_send && sq_pos < DEPTH) begin
								r.byte_action = BYTE_TX;
								r.byte_value = tx_store[sq_pos[3:0]];
								sq_pos = sq_pos + 8'd1;
							end else if (sq_rcv != 8'd0) begin
								r.bus_command = BUS_RESTART;
								r.address_valid = 1'b1;
								r.address_byte = {sq_addr, 1'b1};
								sq_phase = PH_RX;
								sq_pos = '0;
							end else begin
								sq_phase = PH_IDLE;
								r.bus_command = BUS_STOP;
							end
						end
						PH_IDLE: r.clear_master_flag = 1'b1;
						default: ;
					endcase
				end
			end
			OP_SLAVE_BYTE: begin
				sq_quiet = '0;
				if (sq_phase == PH_RX) begin
					r.byte_action = BYTE_RX;
					r.byte_value = rq.data_byte;
					r.byte_index = sq_pos;
					if ({1'b0, sq_pos} + 9'd1 < {1'b0, sq_rcv}) begin
						sq_pos = sq_pos + 8'd1;
						r.ack_action = ACK_ACK;
						r.bus_command = BUS_READ;
					end else begin
						r.ack_action = ACK_NACK;
						r.bus_command = BUS_STOP;
						sq_phase = PH_IDLE;
					end
				end else if (sq_phase == PH_IDLE) begin
					r.ack_action = ACK_NACK;
					r.bus_command = BUS_STOP;
				end
			end
			OP_TICK: begin
				sq_quiet = sq_quiet + 16'd1;
				if (sq_quiet >= sq_timeout) begin
					sq_quiet = '0;
					if (sq_phase != PH_IDLE)
						sq_phase = PH_ERROR;
				end
			end
			OP_CLOSE: begin
				if (sq_active == rq.requested_number) begin
					sq_active = '0;
					sq_phase = PH_IDLE;
				end
			end
			OP_CLEAR_ERR: begin
				if (sq_phase == PH_ERROR)
					sq_phase = PH_IDLE;
			end
			OP_LOAD_TX: begin
				if (rq.tx_index < DEPTH)
					tx_store[rq.tx_index] = rq.data_byte;
			end
			OP_BUS_ERR: begin
				sq_phase = PH_IDLE;
				sq_quiet = '0;
			end
			default: ;
		endcase
		r.status = sq_phase;
		r.current_number = sq_active;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 50)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d expected %0d",
				results_seen, name, got, want));
	endtask

	// driver: new request only once the previous one was taken
	always @(negedge clk) begin : driver
		item_t nx;
		if (!in_valid || req_taken) begin
			if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nx = request_backlog.pop_front();
				in_valid <= 1'b1;
				opcode <= nx.opcode;
				target_address <= nx.target_address;
				command_byte <= nx.command_byte;
				tx_count <= nx.tx_count;
				rx_count <= nx.rx_count;
				requested_number <= nx.requested_number;
				bus_idle <= nx.bus_idle;
				nack_received <= nx.nack_received;
				data_byte <= nx.data_byte;
				tx_index <= nx.tx_index;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : hold_counter
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(negedge clk) begin : receiver
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor
		item_t rq;
		result_t want;
		req_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			rq.opcode = opcode_t'(opcode);
			rq.target_address = target_address;
			rq.command_byte = command_byte;
			rq.tx_count = tx_count;
			rq.rx_count = rx_count;
			rq.requested_number = requested_number;
			rq.bus_idle = bus_idle;
			rq.nack_received = nack_received;
			rq.data_byte = data_byte;
			rq.tx_index = tx_index;
			owed_results.push_back(advance_sequencer(rq));
			requests_taken++;
		end
		if (out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request outstanding",
					results_seen));
			end else begin
				want = owed_results.pop_front();
				check_field("accepted_number", accepted_number, want.accepted_number);
				check_field("bus_command", bus_command, want.bus_command);
				check_field("address_valid", address_valid, want.address_valid);
				check_field("address_byte", address_byte, want.address_byte);
				check_field("byte_action", byte_action, want.byte_action);
				check_field("byte_value", byte_value, want.byte_value);
				check_field("byte_index", byte_index, want.byte_index);
				check_field("ack_action", ack_action, want.ack_action);
				check_field("clear_master_flag", clear_master_flag, want.clear_master_flag);
				check_field("status", status, want.status);
				check_field("current_number", current_number, want.current_number);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL i2c_transaction_sequencer");
			$finish;
		end
	end

	function automatic item_t noise_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(item_t)-1:0];
	endfunction

	// random filler in the fields the opcode does not use
	function automatic item_t req_of(opcode_t op);
		item_t it;
		it = noise_item();
		it.opcode = op;
		return it;
	endfunction

	task automatic push_req(item_t it);
		request_backlog.push_back(it);
		requests_queued++;
	endtask

	task automatic maybe_disturb();
		if ($urandom_range(7) == 0)
			push_req(req_of(OP_TICK));
		if ($urandom_range(39) == 0)
			push_req(noise_item());
	endtask

	// one write-then-read transaction as the bus engine would report it
	task automatic add_transaction();
		item_t it;
		int n_tx;
		int n_rx;
		logic [7:0] num;
		if ($urandom_range(2) == 0)
			push_req(req_of(OP_LOAD_TX));
		it = req_of(OP_START);
		it.tx_count = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(4));
		it.rx_count = ($urandom_range(39) == 0) ? 8'($urandom_range(255)) :
			8'($urandom_range(4));
		it.requested_number = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
		it.bus_idle = ($urandom_range(4) != 0);
		n_tx = (it.tx_count > DEPTH) ? DEPTH : int'(it.tx_count);
		n_rx = it.rx_count;
		num = it.requested_number;
		push_req(it);
		// command byte, the transmit bytes, then restart or stop
		for (int k = 0; k < n_tx + 2; k++) begin
			maybe_disturb();
			it = req_of(OP_MASTER_EVT);
			it.nack_received = ($urandom_range(29) == 0);
			push_req(it);
		end
		for (int k = 0; k < n_rx; k++) begin
			maybe_disturb();
			push_req(req_of(OP_SLAVE_BYTE));
		end
		case ($urandom_range(5))
			0: begin
				it = req_of(OP_CLOSE);
				it.requested_number = num;
				push_req(it);
			end
			1: push_req(req_of(OP_CLEAR_ERR));
			2: push_req(req_of(OP_BUS_ERR));
			3: push_req(req_of(OP_CLOSE));
			default: ;
		endcase
	endtask

	task automatic fill_random(int count);
		item_t it;
		int stop_at;
		stop_at = requests_queued + count;
		// burst of allocating starts, to push the number counter around its wrap
		repeat (50) begin
			it = req_of(OP_START);
			it.bus_idle = 1'b1;
			it.requested_number = 8'd0;
			push_req(it);
		end
		while (requests_queued < stop_at) begin
			if ($urandom_range(9) == 0)
				push_req(noise_item());
			else
				add_transaction();
		end
	endtask

	task automatic drain();
		while (requests_taken != requests_queued || owed_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(logic [15:0] ms);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = ms;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sq_timeout = ms;
	endtask

	initial begin : stimulus
		item_t it;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		for (int k = 0; k < DEPTH; k++)
			tx_store[k] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole transmit buffer first so no unloaded entry is ever sent
		for (int k = 0; k < DEPTH; k++) begin
			it = req_of(OP_LOAD_TX);
			it.tx_index = 4'(k);
			it.data_byte = 8'(k * 17);
			push_req(it);
		end

		// idle corner requests
		it = req_of(OP_MASTER_EVT);
		it.nack_received = 1'b0;
		push_req(it);
		it.data_byte = 8'h5A;
		it.opcode = OP_SLAVE_BYTE;
		push_req(it);
		it = req_of(OP_MASTER_EVT);
		it.nack_received = 1'b1;
		push_req(it);
		// start refused while in error
		it = req_of(OP_START);
		it.bus_idle = 1'b0;
		push_req(it);
		push_req(req_of(OP_TICK));
		push_req(req_of(OP_CLEAR_ERR));
		it = req_of(OP_CLOSE);
		it.requested_number = 8'd0;
		push_req(it);

		// full write-then-read with extreme fields
		it = req_of(OP_START);
		it.target_address = 7'h7F;
		it.command_byte = 8'hFF;
		it.tx_count = 5'd2;
		it.rx_count = 8'd2;
		it.requested_number = 8'hFF;
		it.bus_idle = 1'b0;
		push_req(it);
		repeat (4) begin
			it = req_of(OP_MASTER_EVT);
			it.nack_received = 1'b0;
			push_req(it);
		end
		it = req_of(OP_SLAVE_BYTE);
		it.data_byte = 8'hFF;
		push_req(it);
		it.data_byte = 8'h00;
		push_req(it);
		it = req_of(OP_CLOSE);
		it.requested_number = 8'hFE;
		push_req(it);
		it.requested_number = 8'hFF;
		push_req(it);

		// oversized transmit count, target does not answer its address
		it = req_of(OP_START);
		it.target_address = 7'h00;
		it.command_byte = 8'h00;
		it.tx_count = 5'd31;
		it.rx_count = 8'd0;
		it.requested_number = 8'd0;
		it.bus_idle = 1'b0;
		push_req(it);
		it = req_of(OP_MASTER_EVT);
		it.nack_received = 1'b1;
		push_req(it);
		push_req(req_of(OP_SLAVE_BYTE));
		// start while unreachable, write only, no read
		it = req_of(OP_START);
		it.tx_count = 5'd0;
		it.rx_count = 8'd0;
		it.requested_number = 8'd0;
		it.bus_idle = 1'b0;
		push_req(it);
		repeat (2) begin
			it = req_of(OP_MASTER_EVT);
			it.nack_received = 1'b0;
			push_req(it);
		end
		push_req(req_of(OP_BUS_ERR));
		drain();

		// timeout of 1 ms, no idling, receiver held off for a long stretch
		write_timeout(16'd1);
		fill_random(250);
		@(negedge clk);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		drain();

		write_timeout(16'hFFFF);
		send_idle_pct = 72;
		fill_random(250);
		drain();

		// zero timeout fires on every tick
		write_timeout(16'd0);
		send_idle_pct = 0;
		recv_stall_pct = 72;
		fill_random(250);
		drain();

		// sender pauses until everything outstanding has come back
		write_timeout(16'd5);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		fill_random(125);
		drain();
		fill_random(125);
		drain();

		repeat (8) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("PASS i2c_transaction_sequencer");
		end else begin
			$display("FAIL i2c_transaction_sequencer");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/i2cts_pkg.sv
rtl/core/i2c_transaction_sequencer.sv
tb/i2c_transaction_sequencer_test.sv
